[hdl/mec_pkg.sv]
// shared widths, constants and control types for the escape-time counter
package mec_pkg;

    localparam int FRAC_BITS = 28;
    localparam int CW        = 32;              // width of cx, cy
    localparam int IW        = 10;              // iteration count width
    localparam int XW        = FRAC_BITS + 3;   // holds +-2^(FRAC_BITS+1)
    localparam int PW        = 2 * XW;          // full product width
    localparam int NW        = PW + 2;          // working width of the update

    localparam logic [IW-1:0] MAX_ITER_RESET = IW'(100);

    // escape bound on a single component: 2.0
    localparam logic signed [NW-1:0] LIMIT     = NW'(1) << (FRAC_BITS + 1);
    localparam logic signed [NW-1:0] NEG_LIMIT = -LIMIT;
    // escape bound on |z|^2: 4.0 in the squared format
    localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

    typedef struct packed {
        logic load;     // take a new point, clear z and count
        logic mul;      // register the three products
        logic step;     // commit new z, bump count
        logic finish;   // capture the result
        logic fin_esc;  // result is an escape
        logic fin_inc;  // escape belongs to the step being computed now
    } mec_cmd_t;

    typedef struct packed {
        logic sum_esc;  // |z|^2 > 4 for the committed z
        logic over;     // a new component is beyond 2.0
        logic n_zero;
        logic n_at_max;
    } mec_stat_t;

endpackage

[hdl/mandelbrot_escape_counter_top.sv]
// top level of the mandelbrot escape-time counter
// A point is taken when start is high and busy is low; one word of result
// (escaped, iterations) follows, shown for a single cycle with done high, and
// the receiver cannot stall it. Each iteration of z = z*z + c registers the
// three products of the shared multiplier set, then updates z and tests it; an
// escape through a component beyond 2.0 is found in the update that computes it,
// one found by the |z|^2 test only from the products of the committed z. done is
// high, with the result, in the first cycle in which busy is low, and a new
// point may be taken in that same cycle.
// max_iterations is written through cfg_valid/cfg_ready, accepted while idle.
module mandelbrot_escape_counter_top
    import mec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CW-1:0] cx,
    input  logic signed [CW-1:0] cy,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IW-1:0]        cfg_data,
    output logic                 done,
    output logic                 escaped,
    output logic [IW-1:0]        iterations
);

    mec_cmd_t  cmd;
    mec_stat_t stat;

    assign cfg_ready = !busy;

    mec_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mec_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cx         (cx),
        .cy         (cy),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .escaped    (escaped),
        .iterations (iterations)
    );

endmodule

[hdl/mec_ctrl.sv]
// sequencer for the escape-time counter: multiply and update phases
module mec_ctrl
    import mec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  mec_stat_t stat,
    output mec_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // the products now hold the squares of the committed z
                if (!stat.n_zero && stat.sum_esc)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_esc = 1'b1;
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                end
                else if (stat.n_at_max)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else if (stat.over)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_esc = 1'b1;
                    cmd.fin_inc = 1'b1;
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[hdl/mec_datapath.sv]
// z registers, product registers, update arithmetic, counter and result
module mec_datapath
    import mec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mec_cmd_t             cmd,
    input  logic signed [CW-1:0] cx,
    input  logic signed [CW-1:0] cy,
    input  logic                 cfg_write,
    input  logic [IW-1:0]        cfg_data,
    output mec_stat_t            stat,
    output logic                 escaped,
    output logic [IW-1:0]        iterations
);

    logic [IW-1:0]        max_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [PW-1:0] xx_reg, yy_reg, xy_reg;
    logic [IW-1:0]        n_reg;
    logic                 escaped_reg;
    logic [IW-1:0]        iterations_reg;

    logic signed [NW-1:0] diff, xy2, nx, ny;
    logic [PW:0]          mag_sum;
    logic [IW-1:0]        n_inc;

    always_comb
    begin
        diff    = NW'(xx_reg) - NW'(yy_reg);
        xy2     = NW'(xy_reg) <<< 1;
        // arithmetic shift is floor division by 2^FRAC_BITS
        nx      = (diff >>> FRAC_BITS) + NW'(cx_reg);
        ny      = (xy2 >>> FRAC_BITS) + NW'(cy_reg);
        mag_sum = (PW + 1)'($unsigned(xx_reg)) + (PW + 1)'($unsigned(yy_reg));
        n_inc   = n_reg + IW'(1);

        stat.sum_esc  = (mag_sum > FOUR);
        stat.over     = (nx > LIMIT) || (nx < NEG_LIMIT) ||
                        (ny > LIMIT) || (ny < NEG_LIMIT);
        stat.n_zero   = (n_reg == '0);
        stat.n_at_max = (n_reg == max_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_ITER_RESET;
        end
        else if (cfg_write)
        begin
            max_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= cx;
            cy_reg <= cy;
            x_reg  <= '0;
            y_reg  <= '0;
            n_reg  <= '0;
        end
        else if (cmd.step)
        begin
            // within +-2.0 here, so the narrow z holds the value exactly
            x_reg <= nx[XW-1:0];
            y_reg <= ny[XW-1:0];
            n_reg <= n_inc;
        end

        if (cmd.mul)
        begin
            xx_reg <= PW'(x_reg) * PW'(x_reg);
            yy_reg <= PW'(y_reg) * PW'(y_reg);
            xy_reg <= PW'(x_reg) * PW'(y_reg);
        end

        if (cmd.finish)
        begin
            escaped_reg    <= cmd.fin_esc;
            iterations_reg <= cmd.fin_esc ? (cmd.fin_inc ? n_inc : n_reg) : '0;
        end
    end

    assign escaped    = escaped_reg;
    assign iterations = iterations_reg;

endmodule

[dv/mandelbrot_escape_counter_top_test.sv]
// self-checking testbench for the mandelbrot escape-time counter top level
`timescale 1ns / 1ps

module mandelbrot_escape_counter_top_test;
    import mec_pkg::*;

    localparam int ONE         = 1 << FRAC_BITS;   // 1.0 in the point format
    localparam int STALL_LIMIT = 20000;
    localparam int N_ROWS      = 22;
    localparam int N_PHASES    = 8;

    typedef struct packed {
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
        logic                 esc;
        logic [IW-1:0]        iters;
    } escape_word_t;

    typedef struct packed {
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
        logic                 known;
        logic                 esc;
        logic [IW-1:0]        iters;
    } point_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] cx        = '0;
    logic signed [CW-1:0] cy        = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IW-1:0]        cfg_data  = '0;
    logic                 done;
    logic                 escaped;
    logic [IW-1:0]        iterations;

    // typed expectation travels with the point, sampled at the same edge
    logic                 row_known = 1'b0;
    logic                 row_esc   = 1'b0;
    logic [IW-1:0]        row_iters = '0;

    logic [IW-1:0]        limit_model = MAX_ITER_RESET;
    escape_word_t         expected_escapes[$];
    int                   mismatch_cnt = 0;
    int                   stall_cycles = 0;
    int                   burst_left   = 1;

    // extremes and typed answers at the reset limit of 100
    point_row_t dir_rows [0:N_ROWS-1] = '{
        '{32'sd0, 32'sd0, 1'b1, 1'b0, 10'd0},
        '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b1, 10'd1},
        '{32'sh80000000, 32'sh80000000, 1'b1, 1'b1, 10'd1},
        '{32'sh7FFFFFFF, 32'sd0, 1'b1, 1'b1, 10'd1},
        '{32'sh80000000, 32'sd0, 1'b1, 1'b1, 10'd1},
        '{32'sd0, 32'sh7FFFFFFF, 1'b1, 1'b1, 10'd1},
        '{32'sd0, 32'sh80000000, 1'b1, 1'b1, 10'd1},
        '{32'sh7FFFFFFF, 32'sh80000000, 1'b1, 1'b1, 10'd1},
        '{2 * ONE, 32'sd0, 1'b0, 1'b0, 10'd0},
        '{2 * ONE + 1, 32'sd0, 1'b1, 1'b1, 10'd1},
        '{-2 * ONE, 32'sd0, 1'b0, 1'b0, 10'd0},
        '{-2 * ONE - 1, 32'sd0, 1'b1, 1'b1, 10'd1},
        '{32'sd0, 2 * ONE, 1'b0, 1'b0, 10'd0},
        '{32'sd0, -2 * ONE - 1, 1'b1, 1'b1, 10'd1},
        '{ONE + ONE / 2, ONE + ONE / 2, 1'b1, 1'b1, 10'd1},
        '{-ONE, 32'sd0, 1'b0, 1'b0, 10'd0},
        '{ONE / 4, 32'sd0, 1'b0, 1'b0, 10'd0},
        '{-3 * ONE / 4, ONE / 10, 1'b0, 1'b0, 10'd0},
        '{-ONE / 2, -ONE / 2, 1'b0, 1'b0, 10'd0},
        '{3 * ONE / 10, ONE / 2, 1'b0, 1'b0, 10'd0},
        '{-ONE / 10, 32'sd174483046, 1'b0, 1'b0, 10'd0},
        '{32'sd1, -32'sd1, 1'b0, 1'b0, 10'd0}
    };

    // 0 and 1023 are the extremes of the register; -1 picks one at random
    int phase_limit [0:N_PHASES-1] = '{1, 0, 1023, 2, 37, 255, 512, -1};
    int phase_items [0:N_PHASES-1] = '{130, 110, 60, 130, 130, 120, 60, 130};

    mandelbrot_escape_counter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cx         (cx),
        .cy         (cy),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .escaped    (escaped),
        .iterations (iterations)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // iterate z = z*z + c exactly, floor on the fraction shift
    function automatic escape_word_t escape_count_of(input logic signed [CW-1:0] re,
                                                     input logic signed [CW-1:0] im,
                                                     input logic [IW-1:0] lim);
        escape_word_t      w;
        longint            zx, zy, nx, ny, c_re, c_im;
        longint unsigned   ax, ay, bound, four;
        int                n;
        w.re    = re;
        w.im    = im;
        w.esc   = 1'b0;
        w.iters = '0;
        c_re    = re;
        c_im    = im;
        zx      = 0;
        zy      = 0;
        bound   = 64'd1 << (FRAC_BITS + 1);
        four    = 64'd1 << (2 * FRAC_BITS + 2);
        for (n = 1; n <= int'(lim); n++)
        begin
            nx = ((zx * zx - zy * zy) >>> FRAC_BITS) + c_re;
            ny = ((2 * zx * zy) >>> FRAC_BITS) + c_im;
            ax = (nx < 0) ? -nx : nx;
            ay = (ny < 0) ? -ny : ny;
            if (ax > bound || ay > bound || (ax * ax + ay * ay) > four)
            begin
                w.esc   = 1'b1;
                w.iters = IW'(n);
                return w;
            end
            zx = nx;
            zy = ny;
        end
        return w;
    endfunction

    task automatic note_mismatch(input escape_word_t want, input logic got_esc,
                                 input logic [IW-1:0] got_iters, input bit orphan);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            if (orphan)
                $display("%0t: result escaped=%0d iterations=%0d with no point waiting",
                         $realtime, got_esc, got_iters);
            else
                $display("%0t: point (%h, %h) expected escaped=%0d iterations=%0d, got %0d %0d",
                         $realtime, want.re, want.im, want.esc, want.iters,
                         got_esc, got_iters);
        end
    endtask

    // accepts points, register writes and result words at each edge
    always @(posedge clk)
    begin : monitor
        escape_word_t w;
        bit           moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                w = escape_count_of(cx, cy, limit_model);
                if (row_known)
                begin
                    w.esc   = row_esc;
                    w.iters = row_iters;
                end
                expected_escapes.push_back(w);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_model = cfg_data;
                moved = 1'b1;
            end
            if (done === 1'b1)
            begin
                moved = 1'b1;
                if (expected_escapes.size() == 0)
                    note_mismatch('0, escaped, iterations, 1'b1);
                else
                begin
                    w = expected_escapes.pop_front();
                    if (escaped !== w.esc || iterations !== w.iters)
                        note_mismatch(w, escaped, iterations, 1'b0);
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic feed_point(input logic signed [CW-1:0] re, input logic signed [CW-1:0] im,
                              input logic known, input logic esc_v,
                              input logic [IW-1:0] iters_v, input bit last);
        int gap;
        start     <= 1'b1;
        cx        <= re;
        cy        <= im;
        row_known <= known;
        row_esc   <= esc_v;
        row_iters <= iters_v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (last || burst_left == 0)
        begin
            // noise on the point lines while start is low
            start <= 1'b0;
            cx    <= $urandom;
            cy    <= $urandom;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
            if (!last)
                repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    task automatic write_limit(input logic [IW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_point(output logic signed [CW-1:0] re, output logic signed [CW-1:0] im);
        int unsigned  sel;
        logic signed [CW-1:0] t;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            // the picture window around the set
            re = $urandom_range(0, 7 * ONE / 2) - 5 * ONE / 2;
            im = $urandom_range(0, 3 * ONE) - 3 * ONE / 2;
        end
        else if (sel < 70)
        begin
            // a few lsbs around the circle of radius 2
            case ($urandom_range(0, 2))
                0: re = 2 * ONE;
                1: re = -2 * ONE;
                default: re = 379625062;
            endcase
            im = (re == 379625062) ? re : 0;
            re = re + $urandom_range(0, 8) - 4;
            im = im + $urandom_range(0, 16) - 8;
            if ($urandom_range(0, 1))
            begin
                t  = re;
                re = im;
                im = t;
            end
        end
        else if (sel < 85)
        begin
            re = $urandom;
            im = $urandom;
        end
        else
        begin
            // mostly inside the main cardioid, runs to the limit
            re = $urandom_range(0, 3 * ONE / 4) - ONE / 2;
            im = $urandom_range(0, ONE) - ONE / 2;
        end
    endtask

    initial
    begin : stimulus
        logic signed [CW-1:0] re, im;
        int                   lim;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            feed_point(dir_rows[r].re, dir_rows[r].im, dir_rows[r].known,
                       dir_rows[r].esc, dir_rows[r].iters, r == N_ROWS - 1);

        for (int p = 0; p < N_PHASES; p++)
        begin
            do
                @(posedge clk);
            while (expected_escapes.size() != 0);
            repeat (6) @(posedge clk);
            lim = (phase_limit[p] < 0) ? $urandom_range(1, 1023) : phase_limit[p];
            write_limit(IW'(lim));
            for (int i = 0; i < phase_items[p]; i++)
            begin
                pick_point(re, im);
                feed_point(re, im, 1'b0, 1'b0, '0, i == phase_items[p] - 1);
            end
        end

        do
            @(posedge clk);
        while (expected_escapes.size() != 0);
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/mec_pkg.sv
hdl/mec_ctrl.sv
hdl/mec_datapath.sv
hdl/mandelbrot_escape_counter_top.sv
dv/mandelbrot_escape_counter_top_test.sv
